>>> rtl/label_overlay_compositor_macros.svh
// Assertion macros used by the label overlay compositor result register module.
`ifndef LABEL_OVERLAY_COMPOSITOR_MACROS_SVH
`define LABEL_OVERLAY_COMPOSITOR_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define LOC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("label overlay compositor check failed");
// Check that a condition in one cycle leads to another in the next.
`define LOC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("label overlay compositor check failed");
`else
`define LOC_ASSERT(name, prop)
`define LOC_ASSERT_NEXT(name, pre, post)
`endif
`endif

>>> rtl/loc_pkg.sv
// Types and constants of the label overlay compositor.
package loc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_DISPLAY_MODE = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  // Display modes.
  localparam logic [2:0] MODE_GREY    = 3'd0;
  localparam logic [2:0] MODE_TRUTH   = 3'd1;
  localparam logic [2:0] MODE_PREDICT = 3'd2;
  localparam logic [2:0] MODE_DIFF    = 3'd3;
  localparam logic [2:0] MODE_CONTOUR = 3'd4;

  localparam logic [7:0] LABEL_FG        = 8'd1;
  localparam logic [7:0] LABEL_UNLABELED = 8'd2;

  typedef struct packed {
    logic [7:0] grey_value;
    logic [7:0] truth_label;
    logic [7:0] predicted_label;
  } loc_in_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pixel_row;
    logic [9:0]  pixel_col;
    logic        last_of_item;
    logic        end_of_frame;
  } loc_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } loc_rgb_t;

  // Position flags of one pixel within the frame.
  typedef struct packed {
    logic has_above;
    logic last_row;
    logic above_first;
    logic first_col;
    logic last_col;
    logic eof;
  } loc_pos_t;

endpackage

>>> rtl/label_overlay_compositor.sv
// Top level of the label overlay compositor.
//
// Usage: slice pixels enter on the pixel channel (valid/ready), one beat per
// pixel in raster order, carrying grey value, truth label and predicted label.
// Coloured pixels leave on the rgb channel (valid/ready) with their row and
// column, last_of_item on the final beat caused by a pixel, and end_of_frame
// on the pixel at the last row and column.
// Output lags input by one row: while row r streams in, each pixel emits the
// pixel above it (row r-1); on the last row it emits its own pixel as well.
// The first row of a frame produces no beats unless it is also the last row.
// Timing: a pixel passes the input register and then the result register
// before its beat is presented. With rgb_ready high the block takes one pixel
// per clock, except on the last row, where each pixel yields two beats and
// the next pixel waits for the pending beat to leave. The line store (one
// registered RAM read each for the pixel above and its right) sets the depth.
// Reset clears the counters, the result registers and the configuration to
// grey mode, 1024 x 1024; the line store holds junk until the first row
// of a frame has written it. When rgb_ready is low the result register
// holds, the input register fills, and then pixel_ready drops.
// Configuration writes are taken at once; make them only while idle.
module label_overlay_compositor
  import loc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  loc_in_t     pixel,
  output logic        rgb_valid,
  input  logic        rgb_ready,
  output loc_out_t    rgb,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  // Line store word: older-row flag, predicted, truth, grey.
  localparam int SW    = 25;

  // Configuration registers.
  logic [2:0]  display_mode;
  logic [10:0] frame_width;
  logic [15:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= MODE_GREY;
      frame_width  <= 11'd1024;
      frame_height <= 16'd1024;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DISPLAY_MODE: display_mode <= cfg_data[2:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan position of the pixel on the input port.
  logic             pixel_fire;
  logic [COL_W-1:0] scan_col;
  logic [COL_W-1:0] scan_col_right;
  logic [15:0]      scan_row;
  loc_pos_t         scan_pos;

  assign pixel_fire     = pixel_valid && pixel_ready;
  assign scan_col_right = COL_W'(scan_col + 1'b1);

  loc_scan #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .advance     (pixel_fire),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .col         (scan_col),
    .row         (scan_row),
    .pos         (scan_pos)
  );

  // Input register stage.
  logic             a_valid;
  loc_in_t          a_pix;
  logic [COL_W-1:0] a_col;
  logic [15:0]      a_row;
  loc_pos_t         a_pos;
  logic             a_hit_c;
  logic             a_hit_r;
  logic [SW-1:0]    a_byp;
  logic             a_take;
  logic             q_room;

  // Line store write-back, done when the held pixel leaves the input stage.
  logic [SW-1:0] wr_data;
  logic [SW-1:0] q_c;
  logic [SW-1:0] q_r;

  assign a_take      = a_valid && q_room;
  assign pixel_ready = !a_valid || a_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pixel_fire) begin
      a_valid <= 1'b1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

  // Forward a write that lands on the address read in the same cycle.
  always_ff @(posedge clk) begin
    if (pixel_fire) begin
      a_pix   <= pixel;
      a_col   <= scan_col;
      a_row   <= scan_row;
      a_pos   <= scan_pos;
      a_hit_c <= a_take && (a_col == scan_col);
      a_hit_r <= a_take && (a_col == scan_col_right);
      a_byp   <= wr_data;
    end
  end

  // Two copies of the line store: one read at the column, one at its right.
  loc_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_WIDTH)
  ) u_store_c (
    .clk  (clk),
    .we   (a_take),
    .waddr(a_col),
    .wdata(wr_data),
    .re   (pixel_fire),
    .raddr(scan_col),
    .rdata(q_c)
  );

  loc_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_WIDTH)
  ) u_store_r (
    .clk  (clk),
    .we   (a_take),
    .waddr(a_col),
    .wdata(wr_data),
    .re   (pixel_fire),
    .raddr(scan_col_right),
    .rdata(q_r)
  );

  logic [SW-1:0] above;
  logic [SW-1:0] above_right;
  logic          above_nz;
  logic          right_nz;
  logic          left_nz;
  logic          edge_pix;

  assign above       = a_hit_c ? a_byp : q_c;
  assign above_right = a_hit_r ? a_byp : q_r;
  assign above_nz    = (above[23:16] != 8'd0);
  assign right_nz    = (above_right[23:16] != 8'd0);
  assign wr_data     = {above_nz, a_pix.predicted_label, a_pix.truth_label,
                        a_pix.grey_value};

  // Contour boundary test for the pixel above the held one.
  assign edge_pix = a_pos.above_first || a_pos.first_col || a_pos.last_col ||
                    !above[24] || (a_pix.predicted_label == 8'd0) ||
                    !left_nz || !right_nz;

  // Hold the left neighbour's mask bit for the next pixel above.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_nz <= 1'b0;
    end else if (a_take) begin
      left_nz <= above_nz;
    end
  end

  loc_rgb_t rgb_above;
  loc_rgb_t rgb_own;

  loc_color u_color_above (
    .display_mode(display_mode),
    .grey        (above[7:0]),
    .truth       (above[15:8]),
    .pred        (above[23:16]),
    .edge_pix    (edge_pix),
    .rgb         (rgb_above)
  );

  loc_color u_color_own (
    .display_mode(display_mode),
    .grey        (a_pix.grey_value),
    .truth       (a_pix.truth_label),
    .pred        (a_pix.predicted_label),
    .edge_pix    (1'b1),
    .rgb         (rgb_own)
  );

  loc_out_t beat_above;
  loc_out_t beat_own;
  loc_out_t beat_first;

  always_comb begin
    beat_above.red          = rgb_above.red;
    beat_above.green        = rgb_above.green;
    beat_above.blue         = rgb_above.blue;
    beat_above.pixel_row    = a_row - 16'd1;
    beat_above.pixel_col    = 10'(a_col);
    beat_above.last_of_item = !a_pos.last_row;
    beat_above.end_of_frame = 1'b0;

    beat_own.red            = rgb_own.red;
    beat_own.green          = rgb_own.green;
    beat_own.blue           = rgb_own.blue;
    beat_own.pixel_row      = a_row;
    beat_own.pixel_col      = 10'(a_col);
    beat_own.last_of_item   = 1'b1;
    beat_own.end_of_frame   = a_pos.eof;

    beat_first = a_pos.has_above ? beat_above : beat_own;
  end

  loc_out_q u_out_q (
    .clk      (clk),
    .rst      (rst),
    .push     (a_take && (a_pos.has_above || a_pos.last_row)),
    .push_two (a_pos.has_above && a_pos.last_row),
    .first    (beat_first),
    .second   (beat_own),
    .room     (q_room),
    .out_valid(rgb_valid),
    .out_ready(rgb_ready),
    .out_data (rgb)
  );

endmodule

>>> rtl/loc_ram.sv
// Generic single write, single read RAM with registered read data.
module loc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/loc_scan.sv
// Raster position counters with width and height clamping.
module loc_scan
  import loc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [10:0]                  frame_width,
  input  logic [15:0]                  frame_height,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output logic [15:0]                  row,
  output loc_pos_t                     pos
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = (COL_W + 1 > 11) ? COL_W + 1 : 11;

  logic [COL_W-1:0] col_cnt;
  logic [15:0]      row_cnt;
  logic [WW-1:0]    fw;
  logic [WW-1:0]    w;
  logic [WW-1:0]    c;
  logic [15:0]      h;
  logic [15:0]      r;

  always_comb begin
    fw = WW'(frame_width);
    if (fw == '0) begin
      w = WW'(1);
    end else if (fw > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = fw;
    end
    // Take a counter left past the frame as the last column or row.
    c = (WW'(col_cnt) >= w) ? w - WW'(1) : WW'(col_cnt);
    h = (frame_height == 16'd0) ? 16'd1 : frame_height;
    r = (row_cnt >= h) ? h - 16'd1 : row_cnt;
  end

  assign col             = c[COL_W-1:0];
  assign row             = r;
  assign pos.has_above   = (r != 16'd0);
  assign pos.last_row    = (r == h - 16'd1);
  assign pos.above_first = (r == 16'd1);
  assign pos.first_col   = (c == '0);
  assign pos.last_col    = (c == w - WW'(1));
  assign pos.eof         = (r == h - 16'd1) && (c == w - WW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (advance) begin
      if (c == w - WW'(1)) begin
        col_cnt <= '0;
        row_cnt <= (r == h - 16'd1) ? 16'd0 : r + 16'd1;
      end else begin
        col_cnt <= COL_W'(c + WW'(1));
        row_cnt <= r;
      end
    end
  end

endmodule

>>> rtl/loc_color.sv
// Colour of one pixel: label classification and constant-weight blends.
module loc_color
  import loc_pkg::*;
(
  input  logic [2:0] display_mode,
  input  logic [7:0] grey,
  input  logic [7:0] truth,
  input  logic [7:0] pred,
  input  logic       edge_pix,
  output loc_rgb_t   rgb
);

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_GREEN,
    KIND_YELLOW,
    KIND_RED,
    KIND_BLUE,
    KIND_CONTOUR
  } kind_t;

  kind_t       kind;
  logic [2:0]  ar, ag, ab;
  logic [10:0] br, bg, bb;

  // Round half up to tenths: (a * g + b + 5) / 10 via reciprocal, then clamp.
  function automatic logic [7:0] tenths(input logic [2:0] a, input logic [10:0] b,
                                        input logic [7:0] g);
    logic [11:0] s;
    logic [28:0] p;
    logic [9:0]  q;
    s = 12'(a * g) + 12'(b) + 12'd5;
    p = 29'(s) * 29'd52429;
    q = p[28:19];
    return (q > 10'd255) ? 8'd255 : q[7:0];
  endfunction

  always_comb begin
    kind = KIND_PLAIN;
    case (display_mode)
      MODE_TRUTH: begin
        if (truth == LABEL_FG) kind = KIND_GREEN;
        else if (truth == LABEL_UNLABELED) kind = KIND_YELLOW;
      end
      MODE_PREDICT: begin
        if (pred == LABEL_FG) kind = KIND_RED;
      end
      MODE_DIFF: begin
        if (truth == LABEL_FG && pred == LABEL_FG) kind = KIND_GREEN;
        else if (pred == LABEL_FG) kind = KIND_RED;
        else if (truth == LABEL_FG) kind = KIND_BLUE;
      end
      MODE_CONTOUR: begin
        if (pred == LABEL_FG && edge_pix) kind = KIND_CONTOUR;
      end
      default: kind = KIND_PLAIN;
    endcase
  end

  always_comb begin
    ar = 3'd3; br = 11'd0;
    ag = 3'd3; bg = 11'd0;
    ab = 3'd3; bb = 11'd0;
    case (kind)
      KIND_GREEN: begin
        ag = 3'd4; bg = 11'd1530;
      end
      KIND_YELLOW: begin
        ar = 3'd6; br = 11'd720;
        ag = 3'd6; bg = 11'd640;
        ab = 3'd4;
      end
      KIND_RED: begin
        ar = 3'd4; br = 11'd1530;
      end
      KIND_BLUE: begin
        ab = 3'd4; bb = 11'd1530;
      end
      KIND_CONTOUR: begin
        br = 11'd1785;
        ag = 3'd2;
        ab = 3'd2;
      end
      default: begin
        ar = 3'd3;
      end
    endcase
  end

  always_comb begin
    if (kind == KIND_PLAIN) begin
      rgb.red   = grey;
      rgb.green = grey;
      rgb.blue  = grey;
    end else begin
      rgb.red   = tenths(ar, br, grey);
      rgb.green = tenths(ag, bg, grey);
      rgb.blue  = tenths(ab, bb, grey);
    end
  end

endmodule

>>> rtl/loc_out_q.sv
// Two-slot result register: shown beat plus one pending beat.
module loc_out_q
  import loc_pkg::*;
`include "label_overlay_compositor_macros.svh"
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  logic     push_two,
  input  loc_out_t first,
  input  loc_out_t second,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output loc_out_t out_data
);

  logic     pend_valid;
  loc_out_t pend;

  assign room = !out_valid || (out_ready && !pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (push) begin
      out_valid  <= 1'b1;
      pend_valid <= push_two;
    end else if (out_valid && out_ready) begin
      out_valid  <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= first;
      pend     <= second;
    end else if (out_valid && out_ready && pend_valid) begin
      out_data <= pend;
    end
  end

  `LOC_ASSERT(pend_has_shown, pend_valid |-> out_valid)
  `LOC_ASSERT(shown_not_last, pend_valid |-> !out_data.last_of_item)
  `LOC_ASSERT(eof_is_last, (out_valid && out_data.end_of_frame) |-> out_data.last_of_item)
  `LOC_ASSERT_NEXT(drain_pend, pend_valid && out_ready, out_valid && out_data.last_of_item)

endmodule
